// ===== src/rgbpwe_pkg.sv =====
// shared types, constants and helpers for the rgb pixel pulse-width encoder
package rgbpwe_pkg;

	localparam int CHAN_W  = 8;
	localparam int TICK_W  = 15;
	localparam int WORD_W  = 3 * CHAN_W;
	localparam int SYMBOLS = WORD_W;
	localparam int SYM_W   = $clog2(SYMBOLS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = TICK_W;

	localparam int FIFO_DEPTH_DEF = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;

	localparam logic [CHAN_W-1:0] BRIGHTNESS_RST = 8'd255;
	localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 15'd10;
	localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 15'd40;
	localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 15'd35;
	localparam logic [TICK_W-1:0] ONE_LOW_RST    = 15'd15;

	localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(SYMBOLS - 1);

	typedef struct packed {
		logic [TICK_W-1:0] zero_high;
		logic [TICK_W-1:0] zero_low;
		logic [TICK_W-1:0] one_high;
		logic [TICK_W-1:0] one_low;
	} timing_t;

	function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
			input logic [CHAN_W-1:0] b);
		logic [2*CHAN_W-1:0] p;
		p = c * b;
		return p[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

// ===== src/rgb_pixel_pulse_width_encoder_core.sv =====
// rgb pixel pulse-width encoder: top level with the configuration registers
//
// in channel (in_valid/in_ready, red/green/blue): one pixel per request.
// out channel (out_valid/out_ready): 24 symbols per pixel, green, red, blue,
// msb first; each carries high_ticks/low_ticks for its bit, last marks the 24th.
// cfg_we/cfg_index/cfg_data write brightness and the four tick timings;
// writes are taken at once and should only happen while the block is idle.
// with the pipe empty, the first symbol of a pixel is scaled into the front-end
// register as its request is taken, then queued, then loaded into the symbol
// register.
// throughput: one symbol per cycle while the receiver is ready, set by the
// serializer's single output register; the front end and the queue of
// FIFO_DEPTH words take further pixels while symbols are still going out.
// a stalled receiver holds the current symbol; the queue fills and then
// in_ready drops. reset clears all valid state and loads the register
// defaults (brightness 255, ticks 10/40/35/15).
module rgb_pixel_pulse_width_encoder_core import rgbpwe_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAN_W-1:0]     red,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TICK_W-1:0]     high_ticks,
	output logic [TICK_W-1:0]     low_ticks,
	output logic                  bit_value,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CHAN_W-1:0] brightness_q;
	timing_t           timing_q;
	logic              wr_valid;
	logic              wr_ready;
	logic [WORD_W-1:0] wr_data;
	logic              rd_valid;
	logic              rd_pop;
	logic [WORD_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q       <= BRIGHTNESS_RST;
			timing_q.zero_high <= ZERO_HIGH_RST;
			timing_q.zero_low  <= ZERO_LOW_RST;
			timing_q.one_high  <= ONE_HIGH_RST;
			timing_q.one_low   <= ONE_LOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS: brightness_q       <= cfg_data[CHAN_W-1:0];
				REG_ZERO_HIGH:  timing_q.zero_high <= cfg_data[TICK_W-1:0];
				REG_ZERO_LOW:   timing_q.zero_low  <= cfg_data[TICK_W-1:0];
				REG_ONE_HIGH:   timing_q.one_high  <= cfg_data[TICK_W-1:0];
				REG_ONE_LOW:    timing_q.one_low   <= cfg_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rgbpwe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.brightness (brightness_q),
		.wr_valid   (wr_valid),
		.wr_ready   (wr_ready),
		.wr_data    (wr_data)
	);

	rgbpwe_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_data),
		.rd_valid (rd_valid),
		.rd_pop   (rd_pop),
		.rd_data  (rd_data)
	);

	rgbpwe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (rd_valid),
		.rd_pop     (rd_pop),
		.rd_data    (rd_data),
		.timing     (timing_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.high_ticks (high_ticks),
		.low_ticks  (low_ticks),
		.bit_value  (bit_value),
		.last       (last)
	);

endmodule

// ===== src/rgbpwe_front.sv =====
// front end: takes pixel requests, applies brightness and packs the grb word
module rgbpwe_front import rgbpwe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	input  logic [CHAN_W-1:0] brightness,
	output logic              wr_valid,
	input  logic              wr_ready,
	output logic [WORD_W-1:0] wr_data
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;

	assign in_ready = !valid_s1 || wr_ready;
	assign wr_valid = valid_s1;
	assign wr_data  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= {scale_chan(green, brightness), scale_chan(red, brightness),
				scale_chan(blue, brightness)};
		end
	end

endmodule

// ===== src/rgbpwe_fifo.sv =====
// short word queue between the front end and the symbol serializer
module rgbpwe_fifo import rgbpwe_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [WORD_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_pop,
	output logic [WORD_W-1:0] rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign wr_ready = count_q != FULL_CNT;
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/rgbpwe_back.sv =====
// back end: shifts the word out msb first, one timed symbol per cycle unless stalled
module rgbpwe_back import rgbpwe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_valid,
	output logic              rd_pop,
	input  logic [WORD_W-1:0] rd_data,
	input  timing_t           timing,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TICK_W-1:0] high_ticks,
	output logic [TICK_W-1:0] low_ticks,
	output logic              bit_value,
	output logic              last
);

	logic              busy_q;
	logic [SYM_W-1:0]  cnt_q;
	logic [WORD_W-1:0] word_q;
	logic              adv;
	logic              emit;
	logic              b;

	assign adv    = !out_valid || out_ready;
	// a fresh word is fetched and its first bit sent in the same cycle
	assign rd_pop = adv && !busy_q && rd_valid;
	assign emit   = adv && (busy_q || rd_valid);
	assign b      = busy_q ? word_q[WORD_W-1] : rd_data[WORD_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= emit;
			if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				busy_q <= cnt_q != LAST_SYM;
			end else if (rd_valid) begin
				cnt_q  <= SYM_W'(1);
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q     <= busy_q ? {word_q[WORD_W-2:0], 1'b0} : {rd_data[WORD_W-2:0], 1'b0};
			high_ticks <= b ? timing.one_high : timing.zero_high;
			low_ticks  <= b ? timing.one_low : timing.zero_low;
			bit_value  <= b;
			last       <= busy_q && (cnt_q == LAST_SYM);
		end
	end

endmodule

// ===== src/rgbpwe_checker.sv =====
// port-level checks for the encoder top level, bound in below
module rgbpwe_checker import rgbpwe_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [TICK_W-1:0]     high_ticks,
	input logic [TICK_W-1:0]     low_ticks,
	input logic                  bit_value,
	input logic                  last,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SYM_W-1:0]  sym_cnt_q;
	logic [7:0]        pending_q;
	logic [TICK_W-1:0] zh_q;
	logic [TICK_W-1:0] zl_q;
	logic              out_acc;
	logic              in_acc;
	logic              done;

	assign out_acc = out_valid && out_ready;
	assign in_acc  = in_valid && in_ready;
	assign done    = out_acc && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_cnt_q <= '0;
			pending_q <= '0;
			zh_q      <= ZERO_HIGH_RST;
			zl_q      <= ZERO_LOW_RST;
		end else begin
			if (out_acc) begin
				sym_cnt_q <= last ? '0 : sym_cnt_q + 1'b1;
			end
			if (in_acc && !done) begin
				pending_q <= pending_q + 1'b1;
			end else if (done && !in_acc) begin
				pending_q <= pending_q - 1'b1;
			end
			if (cfg_we && cfg_index == REG_ZERO_HIGH) begin
				zh_q <= cfg_data[TICK_W-1:0];
			end
			if (cfg_we && cfg_index == REG_ZERO_LOW) begin
				zl_q <= cfg_data[TICK_W-1:0];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(high_ticks) && $stable(low_ticks)
			&& $stable(bit_value) && $stable(last))
		else $error("symbol changed while stalled");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last == (sym_cnt_q == LAST_SYM))
		else $error("last flag not on the 24th symbol");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("symbol without a pending pixel");

	a_zero_timing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bit_value |-> high_ticks == zh_q && low_ticks == zl_q)
		else $error("zero bit with wrong timing");

endmodule

bind rgb_pixel_pulse_width_encoder_core rgbpwe_checker u_rgbpwe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.high_ticks (high_ticks),
	.low_ticks  (low_ticks),
	.bit_value  (bit_value),
	.last       (last),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.cfg_data   (cfg_data)
);

// ===== dv/tb_rgb_pixel_pulse_width_encoder_core.sv =====
// testbench for the rgb pixel pulse-width encoder core: pixels in, symbol stream checked out
module tb_rgb_pixel_pulse_width_encoder_core;
	import rgbpwe_pkg::*;

	typedef struct packed {
		logic [TICK_W-1:0] high_t;
		logic [TICK_W-1:0] low_t;
		logic              bitv;
		logic              lastv;
	} symbol_t;

	typedef struct packed {
		logic [CHAN_W-1:0] bri;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              typed;
		logic [WORD_W-1:0] word;
	} pixel_row_t;

	localparam int DIR_ROWS     = 16;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_PIXELS = 26;
	localparam int MAX_WAIT     = 8;
	localparam int PAD_W        = CFG_DATA_W - CHAN_W;
	localparam logic [CFG_IDX_W-1:0] REG_TOP  = '1;
	localparam logic [TICK_W-1:0]    TICK_MAX = '1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [CHAN_W-1:0]     red       = '0;
	logic [CHAN_W-1:0]     green     = '0;
	logic [CHAN_W-1:0]     blue      = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TICK_W-1:0]     high_ticks;
	logic [TICK_W-1:0]     low_ticks;
	logic                  bit_value;
	logic                  last;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// local copy of the register file
	logic [CHAN_W-1:0] bri_q     = BRIGHTNESS_RST;
	logic [TICK_W-1:0] zero_hi_q = ZERO_HIGH_RST;
	logic [TICK_W-1:0] zero_lo_q = ZERO_LOW_RST;
	logic [TICK_W-1:0] one_hi_q  = ONE_HIGH_RST;
	logic [TICK_W-1:0] one_lo_q  = ONE_LOW_RST;

	symbol_t pending_symbols[$];
	int      mismatches = 0;
	bit      quiet      = 1'b0;

	// directed pixels; the word is typed in only where it is obvious
	pixel_row_t dir_rows [DIR_ROWS] = '{
		'{8'd255, 8'h00, 8'h00, 8'h00, 1'b1, 24'h000000},
		'{8'd255, 8'hff, 8'hff, 8'hff, 1'b1, 24'hfefefe},
		'{8'd255, 8'hff, 8'h00, 8'h00, 1'b1, 24'h00fe00},
		'{8'd255, 8'h00, 8'hff, 8'h00, 1'b1, 24'hfe0000},
		'{8'd255, 8'h00, 8'h00, 8'hff, 1'b1, 24'h0000fe},
		'{8'd255, 8'h80, 8'h01, 8'h7f, 1'b0, 24'h000000},
		'{8'd255, 8'haa, 8'h55, 8'hc3, 1'b0, 24'h000000},
		'{8'd255, 8'h01, 8'h80, 8'hfe, 1'b0, 24'h000000},
		'{8'd0,   8'hff, 8'hff, 8'hff, 1'b1, 24'h000000},
		'{8'd0,   8'h12, 8'h34, 8'h56, 1'b1, 24'h000000},
		'{8'd1,   8'hff, 8'hff, 8'hff, 1'b1, 24'h000000},
		'{8'd128, 8'hff, 8'hff, 8'hff, 1'b1, 24'h7f7f7f},
		'{8'd128, 8'h80, 8'h80, 8'h80, 1'b1, 24'h404040},
		'{8'd128, 8'h3c, 8'ha5, 8'h0f, 1'b0, 24'h000000},
		'{8'd255, 8'h55, 8'haa, 8'h3c, 1'b0, 24'h000000},
		'{8'd255, 8'h7f, 8'hfe, 8'h01, 1'b0, 24'h000000}
	};

	rgb_pixel_pulse_width_encoder_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.high_ticks (high_ticks),
		.low_ticks  (low_ticks),
		.bit_value  (bit_value),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] c);
		logic [2*CHAN_W-1:0] prod;
		prod = {{CHAN_W{1'b0}}, c} * {{CHAN_W{1'b0}}, bri_q};
		return CHAN_W'(prod >> CHAN_W);
	endfunction

	// green, red, blue order on the wire
	function automatic logic [WORD_W-1:0] pixel_word(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		return {dim_channel(g), dim_channel(r), dim_channel(b)};
	endfunction

	function automatic void queue_word_symbols(input logic [WORD_W-1:0] word);
		symbol_t s;
		for (int k = 0; k < SYMBOLS; k++) begin
			s.bitv   = word[WORD_W-1-k];
			s.high_t = s.bitv ? one_hi_q : zero_hi_q;
			s.low_t  = s.bitv ? one_lo_q : zero_lo_q;
			s.lastv  = (k == SYMBOLS - 1);
			pending_symbols.push_back(s);
		end
	endfunction

	function automatic logic [CHAN_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [TICK_W-1:0] want,
			input logic [TICK_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BRIGHTNESS: bri_q     = data[CHAN_W-1:0];
			REG_ZERO_HIGH:  zero_hi_q = data[TICK_W-1:0];
			REG_ZERO_LOW:   zero_lo_q = data[TICK_W-1:0];
			REG_ONE_HIGH:   one_hi_q  = data[TICK_W-1:0];
			REG_ONE_LOW:    one_lo_q  = data[TICK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_brightness(input logic [CHAN_W-1:0] value);
		logic [PAD_W-1:0] pad;
		// junk above bit 7 must be dropped
		pad = PAD_W'($urandom);
		write_reg(REG_BRIGHTNESS, {pad, value});
	endtask

	task automatic wait_stream_empty();
		in_valid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b, input logic typed, input logic [WORD_W-1:0] word);
		int gap;
		bit taken;
		gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		// inputs only move at the rising edge, so the falling edge shows what the next edge takes
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		if (typed)
			queue_word_symbols(word);
		else
			queue_word_symbols(pixel_word(r, g, b));
	endtask

	initial begin : receiver
		int stall;
		bit taken;
		@(posedge clk);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = out_valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	always @(negedge clk) begin : symbol_check
		symbol_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_symbols.size() == 0) begin
				$display("%0t: expected no symbol got high=%0d low=%0d bit=%0b last=%0b",
					$time, high_ticks, low_ticks, bit_value, last);
				mismatches++;
			end else begin
				want = pending_symbols.pop_front();
				check_field("high_ticks", want.high_t, high_ticks);
				check_field("low_ticks", want.low_t, low_ticks);
				check_field("bit_value", TICK_W'(want.bitv), TICK_W'(bit_value));
				check_field("last", TICK_W'(want.lastv), TICK_W'(last));
			end
		end
	end

	initial begin : stimulus
		pixel_row_t row;
		logic [CHAN_W-1:0] bri;
		logic [TICK_W-1:0] zh, zl, oh, ol;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = dir_rows[i];
			if (row.bri != bri_q) begin
				wait_stream_empty();
				write_brightness(row.bri);
			end
			send_pixel(row.r, row.g, row.b, row.typed, row.word);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			// registers only change with the stream drained
			wait_stream_empty();
			quiet = (ph == 3);
			zh = TICK_W'($urandom);
			zl = TICK_W'($urandom);
			oh = TICK_W'($urandom);
			ol = TICK_W'($urandom);
			case (ph)
				0: begin
					bri = '1;
					zh = '0; zl = '0; oh = '0; ol = '0;
				end
				1: begin
					bri = '1;
					zh = TICK_MAX; zl = TICK_MAX; oh = TICK_MAX; ol = TICK_MAX;
				end
				2: bri = '0;
				default: bri = CHAN_W'($urandom);
			endcase
			write_brightness(bri);
			write_reg(REG_ZERO_HIGH, zh);
			write_reg(REG_ZERO_LOW, zl);
			write_reg(REG_ONE_HIGH, oh);
			write_reg(REG_ONE_LOW, ol);
			// index past the register file, must leave everything alone
			write_reg(CFG_IDX_W'($urandom_range(REG_ONE_LOW + 1, REG_TOP)),
				CFG_DATA_W'($urandom));
			for (int n = 0; n < PHASE_PIXELS; n++)
				send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
		end

		wait_stream_empty();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb_rgb_pixel_pulse_width_encoder_core OK");
		else
			$display("tb_rgb_pixel_pulse_width_encoder_core NOT OK");
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("tb_rgb_pixel_pulse_width_encoder_core NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
src/rgbpwe_pkg.sv
src/rgbpwe_front.sv
src/rgbpwe_fifo.sv
src/rgbpwe_back.sv
src/rgb_pixel_pulse_width_encoder_core.sv
src/rgbpwe_checker.sv
dv/tb_rgb_pixel_pulse_width_encoder_core.sv
